// ===== rtl/core/frt_pkg.sv =====
`timescale 1ns / 1ps

package frt_pkg;

    localparam int FILES         = 1024;
    localparam int FRAGS         = 64;
    localparam int PAYLOAD_BYTES = 979;

    localparam int FILE_W  = $clog2(FILES);
    localparam int FRAG_W  = $clog2(FRAGS);
    localparam int TOTAL_W = 16;
    localparam int LEN_W   = 10;
    localparam int BYTES_W = 17;
    localparam int DONE_W  = 11;

    localparam logic [BYTES_W-1:0] BYTE_MAX    = '1;
    localparam logic [DONE_W-1:0]  DONE_MAX    = '1;
    localparam logic [LEN_W-1:0]   PAYLOAD_MAX = LEN_W'(PAYLOAD_BYTES);

    localparam int S_DATA_W = 56;
    localparam int M_DATA_W = 16;

    typedef struct packed {
        logic                finished;
        logic [TOTAL_W-1:0]  total;
        logic [BYTES_W-1:0]  bytes;
        logic [FRAGS-1:0]    map;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef struct packed {
        logic clr_en;
        logic accept;
        logic frag_commit;
        logic rep_emit_empty;
        logic scan_load;
        logic scan_shift;
        logic scan_emit;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic out_free;
        logic op_report;
        logic rep_empty;
        logic scan_hit;
        logic scan_last;
    } t_status;

    // fragment j lies inside the announced file when j * PAYLOAD_BYTES <= total, or when total is zero
    function automatic logic [FRAGS-1:0] span_mask(input logic [TOTAL_W-1:0] total);
        logic [FRAGS-1:0] m;
        for (int j = 0; j < FRAGS; j++) begin
            m[j] = (total == '0) || ((j * PAYLOAD_BYTES) <= int'(total));
        end
        return m;
    endfunction

endpackage

// ===== rtl/core/frt_ram.sv =====
`timescale 1ns / 1ps

module frt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/core/frt_ctrl.sv =====
`timescale 1ns / 1ps

module frt_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  frt_pkg::t_status i_status,
    output frt_pkg::t_cmd    o_cmd
);

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_EXEC  = 2'd2;
    localparam logic [1:0] ST_SCAN  = 2'd3;

    logic [1:0]    r_state;
    logic [1:0]    n_state;
    frt_pkg::t_cmd cmd;

    always_comb begin
        n_state    = r_state;
        cmd        = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_CLEAR: begin
                cmd.clr_en = 1'b1;
                if (i_status.clr_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    cmd.accept = 1'b1;
                    n_state    = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (!i_status.op_report) begin
                    if (i_status.out_free) begin
                        cmd.frag_commit = 1'b1;
                        n_state         = ST_IDLE;
                    end
                end else if (i_status.rep_empty) begin
                    if (i_status.out_free) begin
                        cmd.rep_emit_empty = 1'b1;
                        n_state            = ST_IDLE;
                    end
                end else begin
                    cmd.scan_load = 1'b1;
                    n_state       = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (i_status.scan_hit) begin
                    if (i_status.out_free) begin
                        cmd.scan_emit  = 1'b1;
                        cmd.scan_shift = 1'b1;
                        if (i_status.scan_last) begin
                            n_state = ST_IDLE;
                        end
                    end
                end else begin
                    cmd.scan_shift = 1'b1;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_cmd = cmd;

endmodule

// ===== rtl/core/frt_dpath.sv =====
`timescale 1ns / 1ps

module frt_dpath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  frt_pkg::t_cmd                 i_cmd,
    output frt_pkg::t_status              o_status,
    input  logic                          i_cfg_wr_en,
    input  logic [frt_pkg::DONE_W-1:0]    i_cfg_wr_data,
    input  logic                          i_op,
    input  logic [frt_pkg::FILE_W-1:0]    i_file_id,
    input  logic [frt_pkg::FRAG_W-1:0]    i_frag_index,
    input  logic [frt_pkg::TOTAL_W-1:0]   i_total_length,
    input  logic [frt_pkg::LEN_W-1:0]     i_declared_length,
    input  logic [frt_pkg::LEN_W-1:0]     i_received_length,
    input  logic                          i_out_ready,
    output logic                          o_out_valid,
    output logic                          o_accepted,
    output logic                          o_file_complete,
    output logic                          o_all_done,
    output logic                          o_missing_valid,
    output logic [frt_pkg::FRAG_W-1:0]    o_missing_index,
    output logic                          o_last
);

    logic                        r_op;
    logic [frt_pkg::FILE_W-1:0]  r_file_id;
    logic [frt_pkg::FRAG_W-1:0]  r_frag;
    logic [frt_pkg::TOTAL_W-1:0] r_total;
    logic [frt_pkg::LEN_W-1:0]   r_decl;
    logic [frt_pkg::LEN_W-1:0]   r_recv;

    logic [frt_pkg::FILE_W-1:0]  r_clr_addr;
    logic [frt_pkg::DONE_W-1:0]  r_done;
    logic [frt_pkg::DONE_W-1:0]  n_done;
    logic [frt_pkg::DONE_W-1:0]  r_file_count;

    logic [frt_pkg::FRAGS-1:0]   r_mask;
    logic [frt_pkg::FRAG_W-1:0]  r_idx;

    logic                        r_out_valid;
    logic                        r_acc;
    logic                        r_comp;
    logic                        r_all;
    logic                        r_mv;
    logic [frt_pkg::FRAG_W-1:0]  r_mi;
    logic                        r_last;

    frt_pkg::t_entry             rd_entry;
    frt_pkg::t_entry             new_entry;
    logic [frt_pkg::ENTRY_W-1:0] rd_data;
    logic [frt_pkg::ENTRY_W-1:0] wr_data;
    logic [frt_pkg::FILE_W-1:0]  rd_addr;
    logic [frt_pkg::FILE_W-1:0]  wr_addr;
    logic                        wr_en;

    logic                        frag_ok;
    logic [frt_pkg::BYTES_W:0]   byte_sum;
    logic [frt_pkg::BYTES_W-1:0] byte_sat;
    logic                        frag_comp;
    logic [frt_pkg::FRAGS-1:0]   rep_mask;
    logic                        out_free;
    logic                        out_load;

    assign rd_addr = i_cmd.accept ? i_file_id : r_file_id;
    assign wr_en   = i_cmd.clr_en | i_cmd.frag_commit;
    assign wr_addr = i_cmd.clr_en ? r_clr_addr : r_file_id;
    assign wr_data = i_cmd.clr_en ? '0 : new_entry;

    frt_ram #(
        .WIDTH (frt_pkg::ENTRY_W),
        .DEPTH (frt_pkg::FILES)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    assign rd_entry = rd_data;

    always_comb begin
        frag_ok = !rd_entry.finished && !rd_entry.map[r_frag] &&
                  (r_recv == r_decl) && (r_recv <= frt_pkg::PAYLOAD_MAX);
        byte_sum = {1'b0, rd_entry.bytes} + (frt_pkg::BYTES_W + 1)'(r_recv);
        byte_sat = byte_sum[frt_pkg::BYTES_W] ? frt_pkg::BYTE_MAX
                                              : byte_sum[frt_pkg::BYTES_W-1:0];
        frag_comp = frag_ok && (byte_sat >= frt_pkg::BYTES_W'(r_total));

        new_entry = rd_entry;
        if (frag_ok) begin
            new_entry.map      = rd_entry.map | (frt_pkg::FRAGS'(1) << r_frag);
            new_entry.total    = r_total;
            new_entry.bytes    = byte_sat;
            new_entry.finished = frag_comp;
        end

        rep_mask = ~rd_entry.map & frt_pkg::span_mask(rd_entry.total);

        n_done = r_done;
        if (i_cmd.frag_commit && frag_comp && (r_done != frt_pkg::DONE_MAX)) begin
            n_done = r_done + 1'b1;
        end
    end

    assign out_free = !r_out_valid || i_out_ready;
    assign out_load = i_cmd.frag_commit | i_cmd.rep_emit_empty | i_cmd.scan_emit;

    always_comb begin
        o_status.clr_last  = (r_clr_addr == frt_pkg::FILE_W'(frt_pkg::FILES - 1));
        o_status.out_free  = out_free;
        o_status.op_report = r_op;
        o_status.rep_empty = rd_entry.finished || (rep_mask == '0);
        o_status.scan_hit  = r_mask[0];
        o_status.scan_last = (r_mask[frt_pkg::FRAGS-1:1] == '0);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_op      <= i_op;
            r_file_id <= i_file_id;
            r_frag    <= i_frag_index;
            r_total   <= i_total_length;
            r_decl    <= i_declared_length;
            r_recv    <= i_received_length;
        end
        if (i_cmd.scan_load) begin
            r_mask <= rep_mask;
            r_idx  <= '0;
        end else if (i_cmd.scan_shift) begin
            r_mask <= r_mask >> 1;
            r_idx  <= r_idx + 1'b1;
        end
        if (out_load) begin
            r_acc  <= i_cmd.frag_commit & frag_ok;
            r_comp <= i_cmd.frag_commit & frag_comp;
            r_all  <= (n_done >= r_file_count);
            r_mv   <= i_cmd.scan_emit;
            r_mi   <= i_cmd.scan_emit ? r_idx : '0;
            r_last <= !i_cmd.scan_emit || (r_mask[frt_pkg::FRAGS-1:1] == '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr   <= '0;
            r_done       <= '0;
            r_file_count <= frt_pkg::DONE_W'(1);
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cmd.clr_en) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            r_done <= n_done;
            if (i_cfg_wr_en) begin
                r_file_count <= i_cfg_wr_data;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_accepted      = r_acc;
    assign o_file_complete = r_comp;
    assign o_all_done      = r_all;
    assign o_missing_valid = r_mv;
    assign o_missing_index = r_mi;
    assign o_last          = r_last;

endmodule

// ===== rtl/core/fragment_reassembly_tracker.sv =====
`timescale 1ns / 1ps
// Fragment reassembly tracker: per-file bitmap, byte count and announced total.
// Input stream: s_axis_tuser = 0 for an arrived fragment, 1 for a report of the
// missing fragments of one file. Output stream: one word per fragment; a report
// gives one word per missing fragment index (tuser high), or one empty word
// when nothing is missing or the file is finished. tlast marks the final word.
// Configuration: write i_cfg_wr_data with i_cfg_wr_en to set the expected file
// count (reset value 1); write only while the block is idle.
// Sequence: a fragment is accepted, then its row is read from the registered
// file table port and written back, and the result word is registered. A report
// is accepted, its row is read and its bitmap loaded, then the bitmap is scanned
// one bit per cycle up to the last missing one, stalling on a held output word.
// Reset: a clearing pass writes all 1024 table rows, one per cycle, and
// s_axis_tready stays low until the pass is done.
// Stall: a held output word does not block the next input; the block waits
// only when it must place a new word while the held one is not yet taken.
module fragment_reassembly_tracker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_wr_en,
    input  logic [frt_pkg::DONE_W-1:0]     i_cfg_wr_data,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // file_id[9:0], frag_index[15:10], total_length[31:16],
    // declared_length[41:32], received_length[51:42], zero[55:52]
    input  logic [frt_pkg::S_DATA_W-1:0]   s_axis_tdata,
    // operation[0]
    input  logic                           s_axis_tuser,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // accepted[0], file_complete[1], all_done[2], missing_index[8:3], zero[15:9]
    output logic [frt_pkg::M_DATA_W-1:0]   m_axis_tdata,
    // missing_valid[0]
    output logic                           m_axis_tuser,
    output logic                           m_axis_tlast
);

    frt_pkg::t_cmd               cmd;
    frt_pkg::t_status            status;
    logic                        accepted;
    logic                        file_complete;
    logic                        all_done;
    logic [frt_pkg::FRAG_W-1:0]  missing_index;

    frt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    frt_dpath u_dpath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_status          (status),
        .i_cfg_wr_en       (i_cfg_wr_en),
        .i_cfg_wr_data     (i_cfg_wr_data),
        .i_op              (s_axis_tuser),
        .i_file_id         (s_axis_tdata[9:0]),
        .i_frag_index      (s_axis_tdata[15:10]),
        .i_total_length    (s_axis_tdata[31:16]),
        .i_declared_length (s_axis_tdata[41:32]),
        .i_received_length (s_axis_tdata[51:42]),
        .i_out_ready       (m_axis_tready),
        .o_out_valid       (m_axis_tvalid),
        .o_accepted        (accepted),
        .o_file_complete   (file_complete),
        .o_all_done        (all_done),
        .o_missing_valid   (m_axis_tuser),
        .o_missing_index   (missing_index),
        .o_last            (m_axis_tlast)
    );

    assign m_axis_tdata = {7'b0, missing_index, all_done, file_complete, accepted};

endmodule
